FILE: hw/rtl/dbdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode and NMS: shared package
// Types, constants and helpers used by the decode/NMS top level and its store.
// ----------------------------------------------------------------------------
package dbdn_pkg;

  localparam int MaxDetDef = 64;
  localparam int CoordW    = 18;
  localparam int ScoreW    = 16;
  localparam int ClassW    = 8;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;
  localparam int MulAW     = 42;
  localparam int MulBW     = 20;
  localparam int MulPW     = MulAW + MulBW;
  localparam int EdgeW     = 50;

  localparam logic [ScoreW-1:0] ScoreThrRst   = 16'd16384;
  localparam logic [ScoreW-1:0] OverlapThrRst = 16'd29491;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCORE_THR   = 8'd0,
    CFG_OVERLAP_THR = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ClassW-1:0]        cls;
    logic [ScoreW-1:0]        score;
    logic signed [CoordW-1:0] bottom;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] left;
  } entry_t;

  function automatic logic [8:0] anchor_w(input logic layer32, input logic [1:0] anc);
    logic [8:0] r;
    unique case ({layer32, anc})
      3'b001:  r = 9'd23;
      3'b010:  r = 9'd37;
      3'b100:  r = 9'd81;
      3'b101:  r = 9'd135;
      3'b110:  r = 9'd344;
      3'b111:  r = 9'd81;
      default: r = 9'd10;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] anchor_h(input logic layer32, input logic [1:0] anc);
    logic [8:0] r;
    unique case ({layer32, anc})
      3'b001:  r = 9'd27;
      3'b010:  r = 9'd58;
      3'b100:  r = 9'd82;
      3'b101:  r = 9'd169;
      3'b110:  r = 9'd319;
      3'b111:  r = 9'd82;
      default: r = 9'd14;
    endcase
    return r;
  endfunction

  // Q32 to Q14.4, round half up, saturate
  function automatic logic signed [CoordW-1:0] q32_to_q4(input logic signed [EdgeW-1:0] v);
    logic signed [EdgeW-1:0] r;
    logic signed [CoordW-1:0] o;
    r = (v + 50'sd134217728) >>> 28;
    if (r > 50'sd131071) begin
      o = 18'sd131071;
    end else if (r < -50'sd131072) begin
      o = -18'sd131072;
    end else begin
      o = r[CoordW-1:0];
    end
    return o;
  endfunction

endpackage

FILE: hw/rtl/dbdn_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed product, reused for box sizes, areas and IoU test.
// ----------------------------------------------------------------------------
module dbdn_mul
  import dbdn_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [MulPW-1:0] p_o
);

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/dbdn_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box store
// One write port and two registered read ports over the ranked box entries.
// ----------------------------------------------------------------------------
module dbdn_store
  import dbdn_pkg::*;
#(
  parameter int Depth  = MaxDetDef,
  parameter int AddrW  = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output entry_t           rdata_a_o,
  output entry_t           rdata_b_o
);

  entry_t mem [Depth];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/detection_box_decode_nms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode and NMS unit
// Decodes raw detections into corner boxes, keeps them ranked by score and
// runs class-agnostic NMS at the end of each frame.
//
// Channel  Dir  Handshake          Contents
// s_axis   in   tvalid/tready      one raw detection, tlast ends the frame
// m_axis   out  tvalid/tready      one result box, tlast ends the frame
// cfg      in   cfg_we_i           register write, no wait
//
// A detection under the score threshold is dropped; a kept one is decoded on the
// shared multiplier (WW, HH, AW, AH, EDGE) and inserted from the end of the store
// down to its ranked place, first checked against the last entry when full. NMS
// compares each unsuppressed pair and skips suppressed ones; the sink can stall
// emission. s_axis_tready is high only while idle; the output word holds
// until taken. Reset clears the frame state; store contents need no clearing.
// ----------------------------------------------------------------------------
module detection_box_decode_nms_unit
  import dbdn_pkg::*;
#(
  parameter int MaxDetections = MaxDetDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // x_offset, y_offset, width_raw, height_raw, grid_col, grid_row, score,
  // class_label, zero pad
  input  logic [103:0]        s_axis_tdata,
  // layer_select, anchor_index
  input  logic [3:0]          s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // left, top, right, bottom, box_score, box_class
  output logic [95:0]         m_axis_tdata,
  // valid_res, overflowed
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int IdxW = $clog2(MaxDetections);
  localparam int CntW = $clog2(MaxDetections + 1);
  localparam logic [CntW-1:0] Cap = CntW'(MaxDetections);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEC_WW, ST_DEC_HH, ST_DEC_AW, ST_DEC_AH, ST_DEC_EDGE,
    ST_INS_CHK, ST_INS_RD, ST_INS_CMP,
    ST_NMS_I, ST_NMS_J, ST_NMS_GEO, ST_NMS_MI, ST_NMS_MA, ST_NMS_MB,
    ST_NMS_MU, ST_NMS_MT, ST_NMS_CMP,
    ST_EMIT_K, ST_EMIT_RD, ST_EMIT_WAIT
  } state_e;

  state_e state_q;

  logic [ScoreW-1:0] score_thr_q, ovl_thr_q;
  logic [15:0] x_q, y_q, w_q, h_q;
  logic [5:0]  col_q, row_q;
  logic [ScoreW-1:0] score_q;
  logic [ClassW-1:0] cls_q;
  logic        layer32_q, last_q;
  logic [1:0]  anc_q;
  logic [31:0] ww_q, hh_q;
  logic signed [EdgeW-1:0] hw_q;
  entry_t      new_q;

  logic [CntW-1:0] kept_q, i_q, j_q, k_q;
  logic        ovf_q;
  logic [MaxDetections-1:0] supp_q;

  logic signed [18:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
  logic        disjoint_q;
  logic signed [39:0] inter_q, aa_q;
  logic signed [MulAW-1:0] union_q;

  entry_t      out_q;
  logic        out_valid_res_q, out_final_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  logic        mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  entry_t      mem_wdata, rd_a, rd_b;

  logic signed [23:0] vx, vy;
  logic signed [EdgeW-1:0] cx, cy, hh_e;
  entry_t      dec_box;

  logic signed [CoordW-1:0] xl, yt, xr, yb;
  logic        later_surv;
  logic        s_score_ok;
  logic signed [MulPW-1:0] inter_sh;

  dbdn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dbdn_store #(
    .Depth (MaxDetections)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DEC_WW: begin
        mul_a = MulAW'($signed({1'b0, w_q}));
        mul_b = MulBW'($signed({1'b0, w_q}));
      end
      ST_DEC_HH: begin
        mul_a = MulAW'($signed({1'b0, h_q}));
        mul_b = MulBW'($signed({1'b0, h_q}));
      end
      ST_DEC_AW: begin
        mul_a = MulAW'($signed({1'b0, ww_q}));
        mul_b = MulBW'($signed({1'b0, anchor_w(layer32_q, anc_q), 1'b0}));
      end
      ST_DEC_AH: begin
        mul_a = MulAW'($signed({1'b0, hh_q}));
        mul_b = MulBW'($signed({1'b0, anchor_h(layer32_q, anc_q), 1'b0}));
      end
      ST_NMS_MI: begin
        mul_a = MulAW'(iw_q);
        mul_b = MulBW'(ih_q);
      end
      ST_NMS_MA: begin
        mul_a = MulAW'(aw_q);
        mul_b = MulBW'(ah_q);
      end
      ST_NMS_MB: begin
        mul_a = MulAW'(bw_q);
        mul_b = MulBW'(bh_q);
      end
      ST_NMS_MT: begin
        mul_a = union_q;
        mul_b = MulBW'($signed({1'b0, ovl_thr_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // decode edges
  always_comb begin
    vx = $signed({2'b0, col_q, 16'b0}) + $signed({7'b0, x_q, 1'b0}) - 24'sd32768;
    vy = $signed({2'b0, row_q, 16'b0}) + $signed({7'b0, y_q, 1'b0}) - 24'sd32768;
    cx = layer32_q ? (EdgeW'(vx) <<< 21) : (EdgeW'(vx) <<< 20);
    cy = layer32_q ? (EdgeW'(vy) <<< 21) : (EdgeW'(vy) <<< 20);
    hh_e = EdgeW'(mul_p);
    dec_box.cls    = cls_q;
    dec_box.score  = score_q;
    dec_box.left   = q32_to_q4(cx - hw_q);
    dec_box.right  = q32_to_q4(cx + hw_q);
    dec_box.top    = q32_to_q4(cy - hh_e);
    dec_box.bottom = q32_to_q4(cy + hh_e);
  end

  // overlap geometry
  always_comb begin
    xl = (rd_a.left > rd_b.left) ? rd_a.left : rd_b.left;
    yt = (rd_a.top > rd_b.top) ? rd_a.top : rd_b.top;
    xr = (rd_a.right < rd_b.right) ? rd_a.right : rd_b.right;
    yb = (rd_a.bottom < rd_b.bottom) ? rd_a.bottom : rd_b.bottom;
    inter_sh = MulPW'($signed({inter_q, 16'b0}));
  end

  always_comb begin
    later_surv = 1'b0;
    for (int b = 0; b < MaxDetections; b++) begin
      if ((CntW'(b) > k_q) && (CntW'(b) < kept_q) && !supp_q[b]) begin
        later_surv = 1'b1;
      end
    end
  end

  always_comb begin
    mem_we      = (state_q == ST_INS_RD && j_q == '0) || (state_q == ST_INS_CMP);
    mem_waddr   = j_q[IdxW-1:0];
    mem_wdata   = (state_q == ST_INS_CMP && rd_a.score < new_q.score) ? rd_a : new_q;
    mem_raddr_b = j_q[IdxW-1:0];
    unique case (state_q)
      ST_DEC_EDGE: mem_raddr_a = IdxW'(MaxDetections - 1);
      ST_INS_RD:   mem_raddr_a = IdxW'(j_q - CntW'(1));
      ST_NMS_J:    mem_raddr_a = i_q[IdxW-1:0];
      default:     mem_raddr_a = k_q[IdxW-1:0];
    endcase
  end

  assign s_score_ok = s_axis_tdata[91:76] >= score_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      score_thr_q     <= ScoreThrRst;
      ovl_thr_q       <= OverlapThrRst;
      kept_q          <= '0;
      ovf_q           <= 1'b0;
      supp_q          <= '0;
      i_q             <= '0;
      j_q             <= '0;
      k_q             <= '0;
      last_q          <= 1'b0;
      out_valid_res_q <= 1'b0;
      out_final_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCORE_THR) begin
          score_thr_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_OVERLAP_THR) begin
          ovl_thr_q <= cfg_data_i;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_q       <= s_axis_tdata[15:0];
            y_q       <= s_axis_tdata[31:16];
            w_q       <= s_axis_tdata[47:32];
            h_q       <= s_axis_tdata[63:48];
            col_q     <= s_axis_tdata[69:64];
            row_q     <= s_axis_tdata[75:70];
            score_q   <= s_axis_tdata[91:76];
            cls_q     <= s_axis_tdata[99:92];
            layer32_q <= (s_axis_tuser[1:0] == 2'd1);
            anc_q     <= s_axis_tuser[3:2];
            last_q    <= s_axis_tlast;
            i_q       <= '0;
            if (s_score_ok) begin
              state_q <= ST_DEC_WW;
            end else if (s_axis_tlast) begin
              state_q <= ST_NMS_I;
            end
          end
        end
        ST_DEC_WW: state_q <= ST_DEC_HH;
        ST_DEC_HH: begin
          ww_q    <= mul_p[31:0];
          state_q <= ST_DEC_AW;
        end
        ST_DEC_AW: begin
          hh_q    <= mul_p[31:0];
          state_q <= ST_DEC_AH;
        end
        ST_DEC_AH: begin
          hw_q    <= EdgeW'(mul_p);
          state_q <= ST_DEC_EDGE;
        end
        ST_DEC_EDGE: begin
          new_q <= dec_box;
          if (kept_q >= Cap) begin
            ovf_q   <= 1'b1;
            state_q <= ST_INS_CHK;
          end else begin
            j_q     <= kept_q;
            state_q <= ST_INS_RD;
          end
        end
        ST_INS_CHK: begin
          if (rd_a.score < new_q.score) begin
            j_q     <= Cap - CntW'(1);
            state_q <= ST_INS_RD;
          end else begin
            state_q <= last_q ? ST_NMS_I : ST_IDLE;
          end
        end
        ST_INS_RD: begin
          if (j_q == '0) begin
            if (kept_q < Cap) begin
              kept_q <= kept_q + CntW'(1);
            end
            state_q <= last_q ? ST_NMS_I : ST_IDLE;
          end else begin
            state_q <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (rd_a.score < new_q.score) begin
            j_q     <= j_q - CntW'(1);
            state_q <= ST_INS_RD;
          end else begin
            if (kept_q < Cap) begin
              kept_q <= kept_q + CntW'(1);
            end
            state_q <= last_q ? ST_NMS_I : ST_IDLE;
          end
        end
        ST_NMS_I: begin
          if (i_q >= kept_q) begin
            k_q     <= '0;
            state_q <= ST_EMIT_K;
          end else if (supp_q[i_q[IdxW-1:0]]) begin
            i_q <= i_q + CntW'(1);
          end else begin
            j_q     <= i_q + CntW'(1);
            state_q <= ST_NMS_J;
          end
        end
        ST_NMS_J: begin
          if (j_q >= kept_q) begin
            i_q     <= i_q + CntW'(1);
            state_q <= ST_NMS_I;
          end else if (supp_q[j_q[IdxW-1:0]]) begin
            j_q <= j_q + CntW'(1);
          end else begin
            state_q <= ST_NMS_GEO;
          end
        end
        ST_NMS_GEO: begin
          disjoint_q <= (xr < xl) || (yb < yt);
          iw_q       <= 19'(xr) - 19'(xl);
          ih_q       <= 19'(yb) - 19'(yt);
          aw_q       <= 19'(rd_a.right) - 19'(rd_a.left);
          ah_q       <= 19'(rd_a.bottom) - 19'(rd_a.top);
          bw_q       <= 19'(rd_b.right) - 19'(rd_b.left);
          bh_q       <= 19'(rd_b.bottom) - 19'(rd_b.top);
          state_q    <= ST_NMS_MI;
        end
        ST_NMS_MI: state_q <= ST_NMS_MA;
        ST_NMS_MA: begin
          inter_q <= $signed(mul_p[39:0]);
          state_q <= ST_NMS_MB;
        end
        ST_NMS_MB: begin
          aa_q    <= $signed(mul_p[39:0]);
          state_q <= ST_NMS_MU;
        end
        ST_NMS_MU: begin
          union_q <= MulAW'(aa_q) + MulAW'($signed(mul_p[39:0])) - MulAW'(inter_q);
          state_q <= ST_NMS_MT;
        end
        ST_NMS_MT: state_q <= ST_NMS_CMP;
        ST_NMS_CMP: begin
          if (!disjoint_q && (inter_sh > mul_p)) begin
            supp_q[j_q[IdxW-1:0]] <= 1'b1;
          end
          j_q     <= j_q + CntW'(1);
          state_q <= ST_NMS_J;
        end
        ST_EMIT_K: begin
          if (k_q >= kept_q) begin
            out_q           <= '0;
            out_valid_res_q <= 1'b0;
            out_final_q     <= 1'b1;
            state_q         <= ST_EMIT_WAIT;
          end else if (supp_q[k_q[IdxW-1:0]]) begin
            k_q <= k_q + CntW'(1);
          end else begin
            state_q <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          out_q           <= rd_a;
          out_valid_res_q <= 1'b1;
          out_final_q     <= !later_surv;
          state_q         <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (m_axis_tready) begin
            if (out_final_q) begin
              kept_q  <= '0;
              ovf_q   <= 1'b0;
              supp_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + CntW'(1);
              state_q <= ST_EMIT_K;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT_WAIT);
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = {ovf_q, out_valid_res_q};
  assign m_axis_tlast  = out_final_q;

  a_kept_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= Cap) else $error("kept count above capacity");

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while result pending");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (kept_q == '0 && !ovf_q))
    else $error("frame state not cleared after final word");

  a_invalid_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty result not marked final");

endmodule
